@@ design/obc_pkg.sv @@
`default_nettype none

package obc_pkg;

  localparam int CORNER_COUNT     = 8;
  localparam int CORNER_IDX_BITS  = $clog2(CORNER_COUNT);
  localparam int COORD_BITS       = 16;
  localparam int RADIUS_BITS      = 34;
  localparam int CLOUD_BITS       = 16;
  localparam int MIN_CLOUD_POINTS = 5;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 34'd1048576;
  localparam logic [CLOUD_BITS-1:0]  CLOUD_RESET  = 16'hFFFF;

  // stream layout
  localparam int ACTION_BITS    = 2;
  localparam int IN_USER_BITS   = ACTION_BITS + CORNER_IDX_BITS;
  localparam int OUT_DATA_BITS  = 8;
  localparam int OUT_USER_BITS  = 1;
  localparam int OUT_INSIDE_BIT = 0;
  localparam int OUT_COLL_BIT   = 1;
  localparam int OUT_SCORE_BIT  = 2;

  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SEARCH_RADIUS_SQ  = 2'd0,
    CFG_CLOUD_POINT_COUNT = 2'd1
  } cfg_reg_t;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_LOAD_CORNER = 2'd0,
    ACT_LOAD_POSE   = 2'd1,
    ACT_TEST        = 2'd2,
    ACT_FINISH      = 2'd3
  } action_t;

  // box axes run from corner 0 to these corners
  localparam logic [CORNER_IDX_BITS-1:0] AXIS_CORNER [3] = '{3'd3, 3'd1, 3'd2};

  typedef struct packed {
    logic    valid;
    action_t action;
  } ctl_t;

endpackage

`default_nettype wire

@@ design/obc_front.sv @@
`default_nettype none

module obc_front #(
  parameter int COORD_BITS = obc_pkg::COORD_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire obc_pkg::action_t                  in_action,
  input  wire logic [obc_pkg::CORNER_IDX_BITS-1:0] in_corner_index,
  input  wire logic signed [COORD_BITS-1:0]      in_coord [3],
  input  wire logic                              next_ready,
  output obc_pkg::ctl_t                          out_ctl,
  output logic signed [COORD_BITS:0]             dp [3],
  output logic signed [COORD_BITS+3:0]           dd [3],
  output logic signed [COORD_BITS:0]             ax [3][3]
);

  localparam int CW = COORD_BITS;
  localparam int PW = CW + 1;
  localparam int SW = CW + 3;
  localparam int DW = CW + 4;

  logic signed [CW-1:0] corner_store [obc_pkg::CORNER_COUNT][3];
  logic signed [CW-1:0] pose [3];
  logic signed [SW-1:0] corner_sum [3];
  logic                 accept;

  assign in_ready = !out_ctl.valid || next_ready;
  assign accept   = in_valid && in_ready;

  // running corner sum keeps 8*point - sum to one subtract per axis
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < obc_pkg::CORNER_COUNT; i++) begin
        for (int k = 0; k < 3; k++) begin
          corner_store[i][k] <= '0;
        end
      end
      for (int k = 0; k < 3; k++) begin
        pose[k]       <= '0;
        corner_sum[k] <= '0;
      end
    end else if (accept) begin
      if (in_action == obc_pkg::ACT_LOAD_CORNER) begin
        for (int k = 0; k < 3; k++) begin
          corner_store[in_corner_index][k] <= in_coord[k];
          corner_sum[k] <= corner_sum[k] - SW'(corner_store[in_corner_index][k])
                           + SW'(in_coord[k]);
        end
      end
      if (in_action == obc_pkg::ACT_LOAD_POSE) begin
        for (int k = 0; k < 3; k++) begin
          pose[k] <= in_coord[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else if (in_ready) begin
      out_ctl.valid  <= in_valid;
      out_ctl.action <= in_action;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) begin
        dp[k] <= PW'(in_coord[k]) - PW'(pose[k]);
        dd[k] <= (DW'(in_coord[k]) <<< 3) - DW'(corner_sum[k]);
        for (int a = 0; a < 3; a++) begin
          ax[a][k] <= PW'(corner_store[obc_pkg::AXIS_CORNER[a]][k])
                      - PW'(corner_store[0][k]);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ design/obc_arith.sv @@
`default_nettype none

module obc_arith #(
  parameter int COORD_BITS = obc_pkg::COORD_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire obc_pkg::ctl_t                 in_ctl,
  output logic                               up_ready,
  input  wire logic signed [COORD_BITS:0]    dp [3],
  input  wire logic signed [COORD_BITS+3:0]  dd [3],
  input  wire logic signed [COORD_BITS:0]    ax [3][3],
  input  wire logic                          down_ready,
  output obc_pkg::ctl_t                      out_ctl,
  output logic [2*COORD_BITS+1:0]            d2,
  output logic [2*COORD_BITS+1:0]            len2 [3],
  output logic signed [2*COORD_BITS+5:0]     dot [3]
);

  localparam int CW  = COORD_BITS;
  localparam int SQW = 2*CW + 2;
  localparam int MW  = 2*CW + 5;
  localparam int QW  = 2*CW;
  localparam int RW  = 2*CW + 2;
  localparam int TW  = 2*CW + 6;

  obc_pkg::ctl_t         ctl2;
  logic                  en2, en3;
  logic signed [SQW-1:0] dp_sq_full [3];
  logic signed [SQW-1:0] ax_sq_full [3][3];
  logic signed [MW-1:0]  term_full [3][3];
  logic [QW-1:0]         dp_sq [3];
  logic [QW-1:0]         ax_sq [3][3];
  logic signed [MW-1:0]  term [3][3];

  assign en3      = !out_ctl.valid || down_ready;
  assign en2      = !ctl2.valid || en3;
  assign up_ready = en2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dp_sq_full[k] = SQW'(dp[k]) * SQW'(dp[k]);
      for (int a = 0; a < 3; a++) begin
        ax_sq_full[a][k] = SQW'(ax[a][k]) * SQW'(ax[a][k]);
        term_full[a][k]  = MW'(dd[k]) * MW'(ax[a][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid    <= 1'b0;
      out_ctl.valid <= 1'b0;
    end else begin
      if (en2) begin
        ctl2 <= in_ctl;
      end
      if (en3) begin
        out_ctl <= ctl2;
      end
    end
  end

  // products; each square fits in 2*CW bits
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < 3; k++) begin
        dp_sq[k] <= dp_sq_full[k][QW-1:0];
        for (int a = 0; a < 3; a++) begin
          ax_sq[a][k] <= ax_sq_full[a][k][QW-1:0];
          term[a][k]  <= term_full[a][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      d2 <= RW'(dp_sq[0]) + RW'(dp_sq[1]) + RW'(dp_sq[2]);
      for (int a = 0; a < 3; a++) begin
        len2[a] <= RW'(ax_sq[a][0]) + RW'(ax_sq[a][1]) + RW'(ax_sq[a][2]);
        dot[a]  <= TW'(term[a][0]) + TW'(term[a][1]) + TW'(term[a][2]);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/obc_decide.sv @@
`default_nettype none

module obc_decide #(
  parameter int COORD_BITS = obc_pkg::COORD_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [obc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [obc_pkg::RADIUS_BITS-1:0]      cfg_data,
  input  wire obc_pkg::ctl_t                        in_ctl,
  output logic                                      up_ready,
  input  wire logic [2*COORD_BITS+1:0]              d2,
  input  wire logic [2*COORD_BITS+1:0]              len2 [3],
  input  wire logic signed [2*COORD_BITS+5:0]       dot [3],
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic                                      point_inside,
  output logic                                      collided,
  output logic                                      score_valid,
  output logic                                      score
);

  localparam int RW   = 2*COORD_BITS + 2;
  localparam int TW   = 2*COORD_BITS + 6;
  localparam int CMPW = (RW > obc_pkg::RADIUS_BITS) ? RW : obc_pkg::RADIUS_BITS;

  logic [obc_pkg::RADIUS_BITS-1:0] search_radius_sq;
  logic [obc_pkg::CLOUD_BITS-1:0]  cloud_point_count;
  obc_pkg::ctl_t                   ctl4;
  logic                            inside4;
  logic                            hit;
  logic [TW-1:0]                   dot_mag [3];
  logic                            flag;
  logic                            en4, en5;
  logic                            is_finish;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_radius_sq  <= obc_pkg::RADIUS_RESET;
      cloud_point_count <= obc_pkg::CLOUD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        obc_pkg::CFG_SEARCH_RADIUS_SQ:  search_radius_sq  <= cfg_data;
        obc_pkg::CFG_CLOUD_POINT_COUNT:
          cloud_point_count <= cfg_data[obc_pkg::CLOUD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign en5      = !out_valid || out_ready;
  assign en4      = !ctl4.valid || en5;
  assign up_ready = en4;

  // inside: d2 <= radius, |D.u| <= 4|u|^2 per axis, zero-length axis fails
  always_comb begin
    hit = (in_ctl.action == obc_pkg::ACT_TEST) &&
          (CMPW'(d2) <= CMPW'(search_radius_sq));
    for (int a = 0; a < 3; a++) begin
      dot_mag[a] = dot[a][TW-1] ? $unsigned(-dot[a]) : $unsigned(dot[a]);
      if (len2[a] == '0 || dot_mag[a] > TW'({len2[a], 2'b00})) begin
        hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4.valid <= 1'b0;
    end else if (en4) begin
      ctl4 <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      inside4 <= hit;
    end
  end

  assign is_finish = (ctl4.action == obc_pkg::ACT_FINISH);

  // sticky flag is updated in item order as beats enter the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      flag      <= 1'b0;
    end else if (en5) begin
      out_valid <= ctl4.valid;
      if (ctl4.valid) begin
        flag <= is_finish ? 1'b0 : (flag || inside4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && ctl4.valid) begin
      point_inside <= inside4;
      collided     <= flag || inside4;
      score_valid  <= is_finish;
      score        <= is_finish && flag &&
                      (cloud_point_count >= obc_pkg::CLOUD_BITS'(obc_pkg::MIN_CLOUD_POINTS));
    end
  end

endmodule

`default_nettype wire

@@ design/oriented_box_collision_check_top.sv @@
// Channel   Beat fields (low bit first)                          Handshake
// s_axis    tdata: coord_x, coord_y, coord_z                     tvalid/tready
//           tuser: action, corner_index
// m_axis    tdata: point_inside, collided, score                 tvalid/tready
//           tuser: score_valid
// cfg       index 0 search_radius_sq, 1 cloud_point_count        cfg_valid/cfg_ready
//
// One beat per cycle in and out while m_axis_tready stays high.
// Five register stages: capture/subtract, multiply, 3-term sums, compare,
// output register with the sticky collision flag.
// Each stage holds under back-pressure and fills its own bubbles; nothing drops.
// rst (synchronous) clears corners, pose, flag, valid bits and config defaults.
// cfg_ready is always high; write config only with the pipeline empty.
`default_nettype none

module oriented_box_collision_check_top #(
  parameter int COORD_BITS = obc_pkg::COORD_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // coord_x, coord_y, coord_z, zero pad
  input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // action, corner_index
  input  wire logic [obc_pkg::IN_USER_BITS-1:0]       s_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // point_inside, collided, score, zero pad
  output logic [obc_pkg::OUT_DATA_BITS-1:0]           m_axis_tdata,
  // score_valid
  output logic [obc_pkg::OUT_USER_BITS-1:0]           m_axis_tuser,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [obc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [obc_pkg::RADIUS_BITS-1:0]        cfg_data
);

  localparam int CW = COORD_BITS;

  obc_pkg::action_t                   in_action;
  logic [obc_pkg::CORNER_IDX_BITS-1:0] in_corner_index;
  logic signed [CW-1:0]               in_coord [3];

  obc_pkg::ctl_t              ctl1, ctl3;
  logic                       ready2, ready4;
  logic signed [CW:0]         dp [3];
  logic signed [CW+3:0]       dd [3];
  logic signed [CW:0]         ax [3][3];
  logic [2*CW+1:0]            d2;
  logic [2*CW+1:0]            len2 [3];
  logic signed [2*CW+5:0]     dot [3];
  logic                       point_inside, collided, score_valid, score;

  assign in_action       = obc_pkg::action_t'(s_axis_tuser[obc_pkg::ACTION_BITS-1:0]);
  assign in_corner_index = s_axis_tuser[obc_pkg::IN_USER_BITS-1:obc_pkg::ACTION_BITS];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_coord[k] = s_axis_tdata[k*CW +: CW];
    end
  end

  obc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .in_action       (in_action),
    .in_corner_index (in_corner_index),
    .in_coord        (in_coord),
    .next_ready      (ready2),
    .out_ctl         (ctl1),
    .dp              (dp),
    .dd              (dd),
    .ax              (ax)
  );

  obc_arith #(.COORD_BITS(COORD_BITS)) u_arith (
    .clk        (clk),
    .rst        (rst),
    .in_ctl     (ctl1),
    .up_ready   (ready2),
    .dp         (dp),
    .dd         (dd),
    .ax         (ax),
    .down_ready (ready4),
    .out_ctl    (ctl3),
    .d2         (d2),
    .len2       (len2),
    .dot        (dot)
  );

  obc_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_ctl       (ctl3),
    .up_ready     (ready4),
    .d2           (d2),
    .len2         (len2),
    .dot          (dot),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .point_inside (point_inside),
    .collided     (collided),
    .score_valid  (score_valid),
    .score        (score)
  );

  always_comb begin
    m_axis_tdata                          = '0;
    m_axis_tdata[obc_pkg::OUT_INSIDE_BIT] = point_inside;
    m_axis_tdata[obc_pkg::OUT_COLL_BIT]   = collided;
    m_axis_tdata[obc_pkg::OUT_SCORE_BIT]  = score;
    m_axis_tuser                          = obc_pkg::OUT_USER_BITS'(score_valid);
  end

endmodule

`default_nettype wire

@@ design/obc_checker.sv @@
`default_nettype none

module obc_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [obc_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  input wire logic [obc_pkg::OUT_USER_BITS-1:0]   m_axis_tuser
);

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) && !rst |-> !m_axis_tvalid)
    else $error("result beat valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  a_finish_no_inside: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[obc_pkg::OUT_INSIDE_BIT])
    else $error("finish beat reports an inside point");

  a_inside_sets_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[obc_pkg::OUT_INSIDE_BIT] |->
      m_axis_tdata[obc_pkg::OUT_COLL_BIT])
    else $error("inside point without collision flag");

  a_score_needs_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[obc_pkg::OUT_SCORE_BIT] |->
      m_axis_tdata[obc_pkg::OUT_COLL_BIT] && m_axis_tuser[0])
    else $error("collision score without flag or outside a finish beat");

endmodule

bind oriented_box_collision_check_top obc_checker u_obc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
